/* rtl/rfps_pkg.sv */
// Shared types and constants for the rarest-first piece selector.
// Depends on nothing; imported by rfps_qual, the top level and the bench.
`default_nettype none
package rfps_pkg;

  // default sizes, used as the defaults of the top level parameters
  localparam int MaxPiecesDef = 256;
  localparam int MaxPeersDef  = 16;

  // transaction field widths
  localparam int FUNC_W  = 3;
  localparam int PEER_W  = 4;
  localparam int PIECE_W = 8;
  localparam int RAR_W   = 8;
  localparam int IN_TDATA_W  = 24;  // peer, piece, bit_value, rarity, zero fill
  localparam int OUT_TDATA_W = 16;  // found, piece_index, zero fill

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int MODE_W  = 1;
  localparam int PCNT_W  = 9;
  localparam int PEERC_W = 5;
  localparam int BEST_W  = 6;        // holds peer_count + 1

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEL_MODE   = 2'd0,
    CFG_PIECE_CNT  = 2'd1,
    CFG_PEER_CNT   = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_PEER_BIT  = 3'd0,
    FN_PEER_ACT  = 3'd1,
    FN_HAVE_BIT  = 3'd2,
    FN_BUSY_BIT  = 3'd3,
    FN_RARITY    = 3'd4,
    FN_SELECT    = 3'd5,
    FN_RSVD6     = 3'd6,
    FN_RSVD7     = 3'd7
  } func_t;

  localparam logic MODE_RAREST = 1'b0;

  // piece entry layout in the table RAM; peer bits sit from PEER_LSB upwards
  localparam int HAVE_BIT = 0;
  localparam int BUSY_BIT = 1;
  localparam int RAR_LSB  = 2;
  localparam int PEER_LSB = RAR_LSB + RAR_W;

  // verdict of the compare unit on one entry
  typedef struct packed {
    logic qual;  // free and held by an active peer
    logic take;  // replaces the current best
  } qual_t;

endpackage
`default_nettype wire

/* rtl/rfps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; holds the piece table.
`default_nettype none
module rfps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/rfps_qual.sv */
// Compare unit of the scan: judges one piece entry against the running best.
// Depends on rfps_pkg (entry layout, qual_t).
`default_nettype none
module rfps_qual #(
  parameter int MAX_PEERS = rfps_pkg::MaxPeersDef,
  localparam int ENT_W = rfps_pkg::PEER_LSB + MAX_PEERS
) (
  input  wire logic [ENT_W-1:0]          entry,
  input  wire logic [MAX_PEERS-1:0]      holders,
  input  wire logic [rfps_pkg::BEST_W-1:0] best_rar,
  input  wire logic                      seq_mode,
  input  wire logic                      found,
  output rfps_pkg::qual_t                verdict
);
  import rfps_pkg::*;

  logic           held;
  logic           rarer;

  always_comb begin
    held  = |(entry[PEER_LSB +: MAX_PEERS] & holders);
    rarer = entry[RAR_LSB +: RAR_W] < RAR_W'(best_rar);
    verdict.qual = !entry[HAVE_BIT] && !entry[BUSY_BIT] && held;
    // sequential mode keeps the first hit; rarest keeps strictly smaller counts
    verdict.take = verdict.qual && (seq_mode ? !found : rarer);
  end

endmodule
`default_nettype wire

/* rtl/rarest_first_piece_selector.sv */
// Top level of the rarest-first piece selector: sequencer, piece table RAM,
// peer active register and output register. Depends on rfps_pkg, rfps_ram, rfps_qual.
//
//  channel | direction | handshake          | payload
//  in_     | slave     | tvalid / tready    | tuser func; tdata peer, piece, bit_value, rarity
//  out_    | master    | tvalid / tready    | tdata found, piece_index
//  cfg_    | write     | cfg_wr_en          | cfg_index, cfg_data
//
// After reset the table is swept to zero, one entry a cycle, with in_tready low.
// A peer active write, or an unused func code, is taken without leaving S_IDLE.
// A table write is read-modify-write: the entry is read as the write is taken
// and written back in S_WR. A select reads one entry a cycle through the compare
// unit, then waits in S_DONE for out_tready while an earlier result is held.
`default_nettype none
module rarest_first_piece_selector #(
  parameter int MAX_PIECES = rfps_pkg::MaxPiecesDef,
  parameter int MAX_PEERS  = rfps_pkg::MaxPeersDef
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input transactions
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [rfps_pkg::IN_TDATA_W-1:0] in_tdata,  // [3:0] peer, [11:4] piece,
                                                          // [12] bit_value, [20:13] rarity
  input  wire logic [rfps_pkg::FUNC_W-1:0]     in_tuser,  // [2:0] func
  // results
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [rfps_pkg::OUT_TDATA_W-1:0]     out_tdata, // [0] found, [8:1] piece_index
  // configuration
  input  wire logic                            cfg_wr_en,
  input  wire logic [rfps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rfps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rfps_pkg::*;

  localparam int ENT_W  = PEER_LSB + MAX_PEERS;
  localparam int PIDX_W = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
  localparam int CNT_W  = $clog2(MAX_PIECES + 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_WR    = 5'b00100,
    S_SCAN  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic               mode_r;
  logic [PCNT_W-1:0]  piece_cnt_r;
  logic [PEERC_W-1:0] peer_cnt_r;

  // unpacked input transaction
  func_t              in_func;
  logic [PEER_W-1:0]  in_peer;
  logic [PIECE_W-1:0] in_piece;
  logic               in_bit;
  logic [RAR_W-1:0]   in_rar;
  logic               in_acc;
  logic               piece_ok, peer_ok;
  logic [MAX_PEERS-1:0] peer_sel;

  // captured write transaction (payload, no reset)
  func_t                func_r;
  logic [PIDX_W-1:0]    addr_r;
  logic                 bit_r;
  logic [RAR_W-1:0]     rar_r;
  logic [MAX_PEERS-1:0] sel_r;
  logic                 wr_ok_r, wr_ok_nxt;

  logic [MAX_PEERS-1:0] peer_act_r;
  logic [MAX_PEERS-1:0] hold_mask;

  // clear sweep and scan control
  logic [PIDX_W-1:0]    clr_idx_r;
  logic [CNT_W-1:0]     rd_idx_r, limit_r, limit_nxt;
  logic                 issue;
  logic                 chk_vld_r;
  logic [PIDX_W-1:0]    chk_idx_r;
  logic [MAX_PEERS-1:0] holders_r;
  logic [BEST_W-1:0]    best_rar_r;
  logic [PIDX_W-1:0]    best_idx_r;
  logic                 found_r;
  qual_t                verdict;

  // table RAM ports
  logic              ram_we;
  logic [PIDX_W-1:0] ram_waddr, ram_raddr;
  logic [ENT_W-1:0]  ram_wdata, ram_rdata;

  // output register
  logic               out_vld_r;
  logic               out_found_r;
  logic [PIECE_W-1:0] out_idx_r;
  logic               out_load;

  assign in_func  = func_t'(in_tuser);
  assign in_peer  = in_tdata[PEER_W-1:0];
  assign in_piece = in_tdata[PEER_W +: PIECE_W];
  assign in_bit   = in_tdata[PEER_W + PIECE_W];
  assign in_rar   = in_tdata[PEER_W + PIECE_W + 1 +: RAR_W];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign piece_ok = int'(in_piece) < MAX_PIECES;
  assign peer_ok  = int'(in_peer) < MAX_PEERS;

  always_comb begin
    for (int j = 0; j < MAX_PEERS; j++) begin
      peer_sel[j]  = (j == int'(in_peer));
      hold_mask[j] = (j < int'(peer_cnt_r));
    end
    limit_nxt = (int'(piece_cnt_r) < MAX_PIECES) ? CNT_W'(piece_cnt_r) : CNT_W'(MAX_PIECES);
  end

  // only table writes with an in-range piece (and peer, for peer bits) touch the RAM
  always_comb begin
    case (in_func)
      FN_PEER_BIT:                         wr_ok_nxt = piece_ok && peer_ok;
      FN_HAVE_BIT, FN_BUSY_BIT, FN_RARITY: wr_ok_nxt = piece_ok;
      default:                             wr_ok_nxt = 1'b0;
    endcase
  end

  // ---------------- sequencer ----------------
  assign issue = (rd_idx_r < limit_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_idx_r == PIDX_W'(MAX_PIECES - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          if (in_func == FN_SELECT) begin
            state_nxt = S_SCAN;
          end else if (wr_ok_nxt) begin
            state_nxt = S_WR;
          end
        end
      end
      S_WR:   state_nxt = S_IDLE;
      S_SCAN: if (!issue && !chk_vld_r) state_nxt = S_DONE;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  // configuration and peer active bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_RAREST;
      piece_cnt_r <= PCNT_W'(256);
      peer_cnt_r  <= PEERC_W'(16);
      peer_act_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_SEL_MODE:  mode_r      <= cfg_data[MODE_W-1:0];
          CFG_PIECE_CNT: piece_cnt_r <= cfg_data[PCNT_W-1:0];
          CFG_PEER_CNT:  peer_cnt_r  <= cfg_data[PEERC_W-1:0];
          default:       ;
        endcase
      end
      if (in_acc && in_func == FN_PEER_ACT && peer_ok) begin
        peer_act_r <= in_bit ? (peer_act_r | peer_sel) : (peer_act_r & ~peer_sel);
      end
    end
  end

  // capture write transaction; RAM read of the entry runs in the same cycle
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_func;
      addr_r <= PIDX_W'(in_piece);
      bit_r  <= in_bit;
      rar_r  <= in_rar;
      sel_r  <= peer_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ok_r <= 1'b0;
    end else begin
      wr_ok_r <= in_acc && wr_ok_nxt;
    end
  end

  // read-modify-write of one entry
  always_comb begin
    ram_wdata = ram_rdata;
    case (func_r)
      FN_PEER_BIT: ram_wdata[PEER_LSB +: MAX_PEERS] = bit_r ?
                     (ram_rdata[PEER_LSB +: MAX_PEERS] | sel_r) :
                     (ram_rdata[PEER_LSB +: MAX_PEERS] & ~sel_r);
      FN_HAVE_BIT: ram_wdata[HAVE_BIT] = bit_r;
      FN_BUSY_BIT: ram_wdata[BUSY_BIT] = bit_r;
      FN_RARITY:   ram_wdata[RAR_LSB +: RAR_W] = rar_r;
      default:     ;
    endcase
    if (state_r == S_CLEAR) begin
      ram_wdata = '0;
    end
  end

  assign ram_we    = (state_r == S_CLEAR) || (state_r == S_WR && wr_ok_r);
  assign ram_waddr = (state_r == S_CLEAR) ? clr_idx_r : addr_r;
  assign ram_raddr = (state_r == S_SCAN) ? rd_idx_r[PIDX_W-1:0] : PIDX_W'(in_piece);

  rfps_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_PIECES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rfps_qual #(
    .MAX_PEERS (MAX_PEERS)
  ) u_qual (
    .entry    (ram_rdata),
    .holders  (holders_r),
    .best_rar (best_rar_r),
    .seq_mode (mode_r),
    .found    (found_r),
    .verdict  (verdict)
  );

  // scan: entry at rd_idx_r is read, judged in the following cycle as chk_idx_r
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_vld_r <= 1'b0;
      found_r   <= 1'b0;
      rd_idx_r  <= '0;
      limit_r   <= '0;
    end else begin
      chk_vld_r <= (state_r == S_SCAN) && issue;
      if (in_acc && in_func == FN_SELECT) begin
        rd_idx_r <= '0;
        limit_r  <= limit_nxt;
        found_r  <= 1'b0;
      end else begin
        if (state_r == S_SCAN && issue) rd_idx_r <= rd_idx_r + 1'b1;
        if (chk_vld_r && verdict.take) found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r <= rd_idx_r[PIDX_W-1:0];
    if (in_acc && in_func == FN_SELECT) begin
      holders_r  <= peer_act_r & hold_mask;
      best_rar_r <= BEST_W'(peer_cnt_r) + BEST_W'(1);
      best_idx_r <= '0;
    end else if (chk_vld_r && verdict.take) begin
      best_rar_r <= BEST_W'(ram_rdata[RAR_LSB +: RAR_W]);
      best_idx_r <= chk_idx_r;
    end
  end

  // output register: a held result does not block new transactions
  assign out_load = (state_r == S_DONE) && (!out_vld_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r <= found_r;
      out_idx_r   <= found_r ? PIECE_W'(best_idx_r) : '0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_TDATA_W - PIECE_W - 1){1'b0}}, out_idx_r, out_found_r};

`ifndef NO_ASSERTIONS
  // no transaction is taken and no result appears during the clear sweep
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (!in_tready && !chk_vld_r && !out_load))
    else $error("activity during table clear");

  // a not-found result always carries piece index zero
  a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[PIECE_W:1] == '0))
    else $error("not-found result with non-zero index");

  // the scan read pointer never passes the piece limit
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (rd_idx_r <= limit_r))
    else $error("scan pointer past limit");

  // sequential mode keeps the first qualifying piece
  a_seq_first: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && found_r && mode_r) |=> $stable(best_idx_r))
    else $error("sequential mode replaced its first hit");
`endif

endmodule
`default_nettype wire

/* sim/rarest_first_piece_selector_tb.sv */
// Self-checking bench for rarest_first_piece_selector: directed and random table
// writes and selects, checked against an in-bench predictor of the piece scan.
// Depends on rfps_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module rarest_first_piece_selector_tb;
  import rfps_pkg::*;

  localparam int PIECES        = MaxPiecesDef;
  localparam int PEERS         = MaxPeersDef;
  localparam int RANDOM_ITEMS  = 400;  // table or peer writes and selects in the random part
  localparam int MIN_SELECTS   = 40;   // random part runs on until this many selects
  localparam int SETTLE_CYCLES = 8;    // covers the read-modify-write of a table write

  // what one select should return
  typedef struct packed {
    logic               found;
    logic [PIECE_W-1:0] piece_index;
  } pick_t;

  // ---------------------------------------------------------------------------
  // Clock, ports, device
  // ---------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata  = '0;  // [3:0] peer, [11:4] piece, [12] bit_value,
                                          // [20:13] rarity
  logic [FUNC_W-1:0]     in_tuser  = '0;  // [2:0] func
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  logic [OUT_TDATA_W-1:0] out_tdata;      // [0] found, [8:1] piece_index
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SEL_MODE;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  always #2 clk = ~clk;

  rarest_first_piece_selector dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: a shadow of the piece table, peer activity and registers
  // ---------------------------------------------------------------------------
  logic               piece_had     [PIECES];
  logic               piece_busy    [PIECES];
  logic [RAR_W-1:0]   piece_rar_cnt [PIECES];
  logic [PEERS-1:0]   piece_holders [PIECES];
  logic [PEERS-1:0]   peers_online;
  logic               sel_mode;
  logic [PCNT_W-1:0]  scan_count;
  logic [PEERC_W-1:0] peers_used;

  pick_t picks_due[$];   // select results still to come, oldest first

  int    mismatches    = 0;
  int    reqs_sent     = 0;  // accepted transactions other than unused func codes
  int    selects_sent  = 0;
  int    pieces_found  = 0;
  int    settings_seen = 0;
  logic  idle_on       = 1'b1;  // random gaps and stalls allowed
  int    stall_left    = 0;

  // Walks pieces 0..limit-1 as the block does. Sequential mode stops at the
  // first free, held piece; rarest mode keeps the strictly smallest rarity
  // under peer_count+1, so the lowest index wins a tie.
  function automatic pick_t choose_piece();
    int unsigned      lim;
    int unsigned      best_rar;
    int               i;
    logic [PEERS-1:0] holders;
    pick_t            pick;
    lim      = (scan_count > PIECES) ? PIECES : scan_count;
    holders  = (peers_used >= PEERS) ? '1 : ((PEERS'(1) << peers_used) - PEERS'(1));
    holders  = holders & peers_online;
    best_rar = 32'(peers_used) + 32'd1;
    pick     = '0;
    for (i = 0; i < lim; i++) begin
      if (piece_had[i] || piece_busy[i]) continue;
      if ((piece_holders[i] & holders) == '0) continue;
      if (sel_mode != MODE_RAREST) begin
        pick.found       = 1'b1;
        pick.piece_index = i[PIECE_W-1:0];
        break;
      end
      if (32'(piece_rar_cnt[i]) < best_rar) begin
        best_rar         = 32'(piece_rar_cnt[i]);
        pick.found       = 1'b1;
        pick.piece_index = i[PIECE_W-1:0];
      end
    end
    return pick;
  endfunction

  // shadow update for an accepted table or peer write
  function automatic void apply_req(func_t f, logic [PEER_W-1:0] peer,
                                    logic [PIECE_W-1:0] piece, logic bitv,
                                    logic [RAR_W-1:0] rar);
    case (f)
      FN_PEER_BIT: piece_holders[piece][peer] = bitv;
      FN_PEER_ACT: peers_online[peer]         = bitv;
      FN_HAVE_BIT: piece_had[piece]           = bitv;
      FN_BUSY_BIT: piece_busy[piece]          = bitv;
      FN_RARITY:   piece_rar_cnt[piece]       = rar;
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  // One input transaction. tvalid stays high from one transaction to the next
  // unless a gap is drawn; the shadow is updated at the accepting edge.
  task automatic send_req(input func_t f, input logic [PEER_W-1:0] peer,
                          input logic [PIECE_W-1:0] piece, input logic bitv,
                          input logic [RAR_W-1:0] rar);
    pick_t pick;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {{(IN_TDATA_W-21){1'b0}}, rar, bitv, piece, peer};
    do @(posedge clk); while (!in_tready);
    apply_req(f, peer, piece, bitv, rar);
    if (f != FN_RSVD6 && f != FN_RSVD7) reqs_sent++;
    if (f == FN_SELECT) begin
      pick = choose_piece();
      picks_due.insert(picks_due.size(), pick);
      selects_sent++;
      if (pick.found) pieces_found++;
    end
  endtask

  // Holds the sender off until every select has answered and the last table
  // write has had time to land.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; only ever called once settle() has run.
  task automatic set_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_SEL_MODE:  sel_mode   = val[0];
      CFG_PIECE_CNT: scan_count = val[PCNT_W-1:0];
      CFG_PEER_CNT:  peers_used = val[PEERC_W-1:0];
      default: ;
    endcase
  endtask

  // Receiver stalls: random bursts with tready low.
  always @(posedge clk) begin
    if (!rst_n || !idle_on) begin
      out_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking: every accepted result against the oldest select
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_result
    pick_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (picks_due.size() == 0) begin
        $error("result with no select outstanding: found %0d piece_index %0d",
               out_tdata[0], out_tdata[8:1]);
        mismatches++;
      end else begin
        want = picks_due.pop_front();
        if (out_tdata[0] !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, out_tdata[0]);
          mismatches++;
        end
        if (out_tdata[8:1] !== want.piece_index) begin
          $error("piece_index: expected %0d, actual %0d", want.piece_index, out_tdata[8:1]);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Fresh table: nothing held, so nothing found; unused func codes do nothing.
  task automatic test_power_up();
    send_req(FN_SELECT, '0, '0, 1'b0, '0);
    send_req(FN_RSVD6, PEER_W'($urandom), PIECE_W'($urandom), 1'b1, RAR_W'($urandom));
    send_req(FN_RSVD7, PEER_W'($urandom), PIECE_W'($urandom), 1'b1, RAR_W'($urandom));
    send_req(FN_SELECT, '0, '0, 1'b0, '0);
  endtask

  // Rarest mode at reset settings: rarity bound 17, all 256 pieces scanned.
  task automatic test_rarest_choice();
    send_req(FN_PEER_ACT, 4'd15, '0, 1'b1, '0);
    send_req(FN_PEER_BIT, 4'd15, 8'd255, 1'b1, '0);   // top piece, rarity 0
    send_req(FN_SELECT, '0, '0, 1'b0, '0);
    send_req(FN_RARITY, '0, 8'd255, 1'b0, 8'd255);    // rarity over the bound
    send_req(FN_SELECT, '0, '0, 1'b0, '0);
    send_req(FN_PEER_BIT, 4'd15, 8'd0, 1'b1, '0);
    send_req(FN_RARITY, '0, 8'd0, 1'b0, 8'd16);       // just under the bound
    send_req(FN_PEER_BIT, 4'd15, 8'd7, 1'b1, '0);
    send_req(FN_RARITY, '0, 8'd7, 1'b0, 8'd16);       // tie with piece 0
    send_req(FN_SELECT, '0, '0, 1'b0, '0);
    send_req(FN_HAVE_BIT, '0, 8'd0, 1'b1, '0);        // already had
    send_req(FN_SELECT, '0, '0, 1'b0, '0);
    send_req(FN_BUSY_BIT, '0, 8'd7, 1'b1, '0);        // download in progress
    send_req(FN_SELECT, '0, '0, 1'b0, '0);
    send_req(FN_BUSY_BIT, '0, 8'd7, 1'b0, '0);
    send_req(FN_PEER_ACT, 4'd15, '0, 1'b0, '0);       // holder goes away
    send_req(FN_SELECT, '0, '0, 1'b0, '0);
    send_req(FN_PEER_ACT, 4'd0, '0, 1'b1, '0);
    send_req(FN_PEER_BIT, 4'd0, 8'd100, 1'b1, '0);
    send_req(FN_SELECT, '0, '0, 1'b0, '0);
  endtask

  // Sequential mode ignores rarity and takes the lowest free, held piece.
  task automatic test_sequential_choice();
    settle();
    set_reg(CFG_SEL_MODE, 9'd1);
    send_req(FN_SELECT, '0, '0, 1'b0, '0);
    send_req(FN_PEER_BIT, 4'd0, 8'd3, 1'b1, '0);
    send_req(FN_RARITY, '0, 8'd3, 1'b0, 8'd255);
    send_req(FN_SELECT, '0, '0, 1'b0, '0);
  endtask

  // Zero, small, saturating and unused register settings.
  task automatic test_count_limits();
    settle();
    set_reg(CFG_SEL_MODE, 9'd0);
    set_reg(CFG_PEER_CNT, 9'd0);       // no peer counts as holder
    send_req(FN_SELECT, '0, '0, 1'b0, '0);
    settle();
    set_reg(CFG_PEER_CNT, 9'd1);       // peer 0 only, rarity bound 2
    send_req(FN_SELECT, '0, '0, 1'b0, '0);
    settle();
    set_reg(CFG_PEER_CNT, 9'd31);      // past the peer table, bound 32
    send_req(FN_PEER_ACT, 4'd15, '0, 1'b1, '0);
    send_req(FN_SELECT, '0, '0, 1'b0, '0);
    settle();
    set_reg(CFG_PIECE_CNT, 9'd0);      // empty scan
    send_req(FN_SELECT, '0, '0, 1'b0, '0);
    settle();
    set_reg(CFG_PIECE_CNT, 9'd4);
    send_req(FN_SELECT, '0, '0, 1'b0, '0);
    settle();
    set_reg(CFG_PIECE_CNT, 9'd511);    // scan stops at the table size
    set_reg(CFG_UNUSED, 9'h1FF);       // no register behind this index
    send_req(FN_SELECT, '0, '0, 1'b0, '0);
    settings_seen += 6;
  endtask

  // New random register settings, weighted to small scans and extremes.
  task automatic random_settings();
    int unsigned pick;
    set_reg(CFG_SEL_MODE, CFG_DATA_W'($urandom_range(0, 1)));
    pick = $urandom_range(0, 9);
    case (pick)
      0:       set_reg(CFG_PIECE_CNT, 9'd0);
      1:       set_reg(CFG_PIECE_CNT, 9'd1);
      2:       set_reg(CFG_PIECE_CNT, 9'd256);
      3:       set_reg(CFG_PIECE_CNT, 9'd511);
      4:       set_reg(CFG_PIECE_CNT, CFG_DATA_W'($urandom_range(257, 510)));
      default: set_reg(CFG_PIECE_CNT, CFG_DATA_W'($urandom_range(2, 48)));
    endcase
    pick = $urandom_range(0, 9);
    case (pick)
      0:       set_reg(CFG_PEER_CNT, 9'd0);
      1:       set_reg(CFG_PEER_CNT, 9'd1);
      2:       set_reg(CFG_PEER_CNT, 9'd16);
      3:       set_reg(CFG_PEER_CNT, 9'd31);
      4:       set_reg(CFG_PEER_CNT, CFG_DATA_W'($urandom_range(17, 30)));
      default: set_reg(CFG_PEER_CNT, CFG_DATA_W'($urandom_range(2, 15)));
    endcase
    settings_seen++;
  endtask

  // One random transaction. Most land inside the scanned window, on peers in
  // use and with rarities near the bound, so that selects do find pieces;
  // the rest roam the full field ranges.
  task automatic random_req();
    func_t             f;
    int unsigned       roll;
    int unsigned       win;
    int unsigned       pmax;
    logic [PEER_W-1:0] peer;
    logic [PIECE_W-1:0] piece;
    logic [RAR_W-1:0]  rar;
    logic              bitv;
    win  = (scan_count > PIECES || scan_count == 0) ? PIECES : scan_count;
    pmax = (peers_used > PEERS || peers_used == 0) ? PEERS : peers_used;
    roll = $urandom_range(0, 99);
    if (roll < 4)       f = roll[0] ? FN_RSVD7 : FN_RSVD6;
    else if (roll < 16) f = FN_SELECT;
    else if (roll < 40) f = FN_PEER_BIT;
    else if (roll < 52) f = FN_PEER_ACT;
    else if (roll < 64) f = FN_HAVE_BIT;
    else if (roll < 76) f = FN_BUSY_BIT;
    else                f = FN_RARITY;
    peer  = ($urandom_range(0, 4) == 0) ? PEER_W'($urandom_range(0, PEERS - 1))
                                        : PEER_W'($urandom_range(0, pmax - 1));
    piece = ($urandom_range(0, 4) == 0) ? PIECE_W'($urandom_range(0, PIECES - 1))
                                        : PIECE_W'($urandom_range(0, win - 1));
    rar   = ($urandom_range(0, 4) == 0) ? RAR_W'($urandom_range(0, 255))
                                        : RAR_W'($urandom_range(0, peers_used + 2));
    // keep most pieces free and held
    if (f == FN_HAVE_BIT || f == FN_BUSY_BIT) bitv = ($urandom_range(0, 9) < 3);
    else                                      bitv = ($urandom_range(0, 9) < 7);
    send_req(f, peer, piece, bitv, rar);
  endtask

  // Phases of random traffic, each under fresh settings; some phases run
  // without gaps or stalls, and at least one pause drains all results.
  task automatic test_random_traffic();
    int first_req;
    int first_sel;
    int phase;
    first_req = reqs_sent;
    first_sel = selects_sent;
    phase     = 0;
    while (reqs_sent - first_req < RANDOM_ITEMS || selects_sent - first_sel < MIN_SELECTS) begin
      settle();
      random_settings();
      idle_on = (phase % 4 != 3);
      repeat ($urandom_range(50, 70)) random_req();
      phase++;
    end
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_quiet_tail();
    settle();
    random_settings();
    idle_on = 1'b0;
    repeat (40) random_req();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < PIECES; i++) begin
      piece_had[i]     = 1'b0;
      piece_busy[i]    = 1'b0;
      piece_rar_cnt[i] = '0;
      piece_holders[i] = '0;
    end
    peers_online = '0;
    sel_mode     = MODE_RAREST;
    scan_count   = PCNT_W'(PIECES);
    peers_used   = PEERC_W'(PEERS);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // the clearing sweep after reset holds in_tready low; send_req waits it out
    test_power_up();
    test_rarest_choice();
    test_sequential_choice();
    test_count_limits();
    test_random_traffic();
    test_quiet_tail();
    settle();

    if (picks_due.size() != 0) begin
      $error("%0d select results never arrived", picks_due.size());
      mismatches++;
    end
    $display("Run covered %0d transactions and %0d selects (%0d found a piece)",
             reqs_sent, selects_sent, pieces_found);
    $display("under %0d register settings, with %0d mismatches", settings_seen, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far above a run in which every transaction is a full select
  // held up by the longest stalls and gaps.
  initial begin
    #4_000_000;
    $error("watchdog expired with %0d select results outstanding", picks_due.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
